// ----- design/fracture_grid_metrics_assert.svh -----
// assertion macros for the fracture grid metrics block
// needs signals named clock and reset in the scope of each use
`ifndef FRACTURE_GRID_METRICS_ASSERT_SVH
`define FRACTURE_GRID_METRICS_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FGM_ASSERT_IMPLY(label, ante, cons, msg) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define FGM_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define FGM_ASSERT_IMPLY(label, ante, cons, msg)
`define FGM_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- design/fgm_pkg.sv -----
// shared widths and limits for the fracture grid metrics block
// no dependencies
package fgm_pkg;

   localparam int COND_W      = 32;
   localparam int CELL_H_W    = 16;
   localparam int CELL_A_W    = 24;
   localparam int HEIGHT_W    = 24;
   localparam int AREA_W      = 36;
   localparam int WSUM_W      = 64;
   localparam int MEAN_W      = 31;
   localparam int HALF_W      = 36;
   localparam int PROD_W      = COND_W + CELL_A_W;

   // area * 128 / height gives area / height / 2 at 8 fraction bits
   localparam int HALF_SHIFT  = 7;

   localparam int DIV_MEAN_STEPS = WSUM_W;
   localparam int DIV_HALF_STEPS = AREA_W + HALF_SHIFT;
   localparam int DIV_CNT_W      = $clog2(DIV_MEAN_STEPS);

endpackage

// ----- design/fgm_intf.sv -----
// valid/ready channel interfaces for cells and results
// depends on fgm_pkg
interface fgm_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [fgm_pkg::COND_W-1:0]  conductivity;
   logic                               conductivity_infinite;
   logic [fgm_pkg::CELL_H_W-1:0]       cell_height;
   logic [fgm_pkg::CELL_A_W-1:0]       cell_area;
   logic                               column_last;
   logic                               grid_last;

   modport source (output valid, conductivity, conductivity_infinite, cell_height,
                   cell_area, column_last, grid_last, input ready);
   modport sink   (input valid, conductivity, conductivity_infinite, cell_height,
                   cell_area, column_last, grid_last, output ready);
endinterface

interface fgm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [fgm_pkg::HEIGHT_W-1:0]       fracture_height;
   logic [fgm_pkg::AREA_W-1:0]         open_area;
   logic [fgm_pkg::MEAN_W-1:0]         mean_conductivity;
   logic [fgm_pkg::HALF_W-1:0]         half_length;
   logic                               no_open_cells;

   modport source (output valid, fracture_height, open_area, mean_conductivity,
                   half_length, no_open_cells, input ready);
   modport sink   (input valid, fracture_height, open_area, mean_conductivity,
                   half_length, no_open_cells, output ready);
endinterface

// ----- design/fracture_grid_metrics.sv -----
// fracture grid metrics: cell accumulation, then one shared restoring divider
// ordinary cell: capture and product, then accumulate, before the next cell is taken
// grid-last cell: accumulate, 64 + 43 divider steps, result load, before the next cell
// result valid once both divisions finish and load, later while the last one waits
// synchronous active-high reset clears control state and all accumulators
// depends on fgm_pkg, fgm_intf and fracture_grid_metrics_assert.svh
`include "fracture_grid_metrics_assert.svh"

module fracture_grid_metrics (
   input logic        clock,
   input logic        reset,
   fgm_req_if.sink    req_ch,
   fgm_rsp_if.source  rsp_ch
);

   // sequencer states
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_ACC      = 3'd1;
   localparam logic [2:0] ST_DIV_MEAN = 3'd2;
   localparam logic [2:0] ST_DIV_HALF = 3'd3;
   localparam logic [2:0] ST_DONE     = 3'd4;

   localparam int CW = fgm_pkg::DIV_CNT_W;
   localparam int HW = fgm_pkg::HEIGHT_W;
   localparam int AW = fgm_pkg::AREA_W;
   localparam int WW = fgm_pkg::WSUM_W;
   localparam int MW = fgm_pkg::MEAN_W;
   localparam int QW = fgm_pkg::HALF_W;
   localparam int PW = fgm_pkg::PROD_W;
   localparam int HS = fgm_pkg::DIV_HALF_STEPS;

   // control
   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // captured cell
   logic [fgm_pkg::COND_W-1:0]   cond_ff, cond_in;
   logic                         inf_ff, inf_in;
   logic [fgm_pkg::CELL_H_W-1:0] cell_h_ff, cell_h_in;
   logic [fgm_pkg::CELL_A_W-1:0] cell_a_ff, cell_a_in;
   logic                         col_last_ff, col_last_in;
   logic                         grid_last_ff, grid_last_in;
   logic [PW-1:0]                prod_ff, prod_in;

   // accumulators
   logic [HW-1:0] run_ff, run_in;
   logic [HW-1:0] longest_ff, longest_in;
   logic [AW-1:0] area_ff, area_in;
   logic [WW-1:0] wsum_ff, wsum_in;

   // shared divider: dividend shifts out at the top while quotient bits enter below
   logic [WW-1:0] quo_ff, quo_in;
   logic [AW-1:0] rem_ff, rem_in;
   logic [AW-1:0] dvsr_ff, dvsr_in;

   // grid snapshot and pending results
   logic [AW-1:0] snap_area_ff, snap_area_in;
   logic [HW-1:0] snap_height_ff, snap_height_in;
   logic [MW-1:0] mean_res_ff, mean_res_in;
   logic [QW-1:0] half_res_ff, half_res_in;

   // output register
   logic [HW-1:0] rsp_height_ff, rsp_height_in;
   logic [AW-1:0] rsp_area_ff, rsp_area_in;
   logic [MW-1:0] rsp_mean_ff, rsp_mean_in;
   logic [QW-1:0] rsp_half_ff, rsp_half_in;
   logic          rsp_none_ff, rsp_none_in;

   // datapath nets
   logic            req_xfer;
   logic [31:0]     cond_u;
   logic            pos_finite, cell_open, col_end;
   logic [HW:0]     run_sum;
   logic [HW-1:0]   run_open, run_a, run_b, longest_a, longest_b;
   logic [AW:0]     area_sum;
   logic [AW-1:0]   area_new;
   logic [WW:0]     wsum_sum;
   logic [WW-1:0]   wsum_new;
   logic [AW:0]     div_shifted;
   logic [AW-1:0]   div_diff;
   logic            div_take;
   logic [AW-1:0]   rem_step;
   logic [WW-1:0]   quo_step;
   logic [MW-1:0]   mean_sat;
   logic [QW-1:0]   half_sat;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign cond_u       = req_ch.conductivity;

   // one 32x24 product per cell, registered before the accumulate
   assign prod_in = PW'(cond_u) * PW'(req_ch.cell_area);

   // open run and area bookkeeping for the captured cell
   always_comb begin
      pos_finite = !inf_ff && !cond_ff[fgm_pkg::COND_W-1] && (cond_ff != '0);
      cell_open  = inf_ff || pos_finite;
      col_end    = col_last_ff || grid_last_ff;

      run_sum  = {1'b0, run_ff} + (HW+1)'(cell_h_ff);
      run_open = run_sum[HW] ? {HW{1'b1}} : run_sum[HW-1:0];

      // a closed cell ends the run before the column check
      longest_a = (!cell_open && (run_ff > longest_ff)) ? run_ff : longest_ff;
      run_a     = cell_open ? run_open : '0;

      // column or grid end closes whatever run is left
      longest_b = (col_end && (run_a > longest_a)) ? run_a : longest_a;
      run_b     = col_end ? '0 : run_a;

      area_sum = {1'b0, area_ff} + (AW+1)'(cell_a_ff);
      wsum_sum = {1'b0, wsum_ff} + (WW+1)'(prod_ff);
      if (pos_finite) begin
         area_new = area_sum[AW] ? {AW{1'b1}} : area_sum[AW-1:0];
         wsum_new = wsum_sum[WW] ? {WW{1'b1}} : wsum_sum[WW-1:0];
      end else begin
         area_new = area_ff;
         wsum_new = wsum_ff;
      end
   end

   // one restoring divider step
   always_comb begin
      div_shifted = {rem_ff, quo_ff[WW-1]};
      // remainder stays below the divisor, so the low bits carry the whole difference
      div_diff    = div_shifted[AW-1:0] - dvsr_ff;
      div_take    = (div_shifted >= {1'b0, dvsr_ff});
      rem_step    = div_take ? div_diff : div_shifted[AW-1:0];
      quo_step    = {quo_ff[WW-2:0], div_take};

      // zero divisor leaves all ones here; the zero checks discard it
      if (snap_area_ff == '0) begin
         mean_sat = '0;
      end else if (|quo_step[WW-1:MW]) begin
         mean_sat = {MW{1'b1}};
      end else begin
         mean_sat = quo_step[MW-1:0];
      end

      if (snap_height_ff == '0) begin
         half_sat = '0;
      end else if (|quo_step[HS-1:QW]) begin
         half_sat = {QW{1'b1}};
      end else begin
         half_sat = quo_step[QW-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff;
      cond_in        = cond_ff;
      inf_in         = inf_ff;
      cell_h_in      = cell_h_ff;
      cell_a_in      = cell_a_ff;
      col_last_in    = col_last_ff;
      grid_last_in   = grid_last_ff;
      run_in         = run_ff;
      longest_in     = longest_ff;
      area_in        = area_ff;
      wsum_in        = wsum_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      dvsr_in        = dvsr_ff;
      snap_area_in   = snap_area_ff;
      snap_height_in = snap_height_ff;
      mean_res_in    = mean_res_ff;
      half_res_in    = half_res_ff;
      rsp_height_in  = rsp_height_ff;
      rsp_area_in    = rsp_area_ff;
      rsp_mean_in    = rsp_mean_ff;
      rsp_half_in    = rsp_half_ff;
      rsp_none_in    = rsp_none_ff;

      // result taken by the sink
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cond_in      = req_ch.conductivity;
               inf_in       = req_ch.conductivity_infinite;
               cell_h_in    = req_ch.cell_height;
               cell_a_in    = req_ch.cell_area;
               col_last_in  = req_ch.column_last;
               grid_last_in = req_ch.grid_last;
               state_in     = ST_ACC;
            end
         end
         ST_ACC: begin
            if (grid_last_ff) begin
               // snapshot the grid, clear for the next one, start weighted / area
               snap_area_in   = area_new;
               snap_height_in = longest_b;
               quo_in         = wsum_new;
               rem_in         = '0;
               dvsr_in        = area_new;
               cnt_in         = '0;
               run_in         = '0;
               longest_in     = '0;
               area_in        = '0;
               wsum_in        = '0;
               state_in       = ST_DIV_MEAN;
            end else begin
               run_in     = run_b;
               longest_in = longest_b;
               area_in    = area_new;
               wsum_in    = wsum_new;
               state_in   = ST_IDLE;
            end
         end
         ST_DIV_MEAN: begin
            quo_in = quo_step;
            rem_in = rem_step;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(fgm_pkg::DIV_MEAN_STEPS - 1)) begin
               // then (area << 7) / height, dividend aligned to the top
               mean_res_in = mean_sat;
               quo_in      = {snap_area_ff, {(WW-AW){1'b0}}};
               rem_in      = '0;
               dvsr_in     = AW'(snap_height_ff);
               cnt_in      = '0;
               state_in    = ST_DIV_HALF;
            end
         end
         ST_DIV_HALF: begin
            quo_in = quo_step;
            rem_in = rem_step;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(HS - 1)) begin
               half_res_in = half_sat;
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_height_in = snap_height_ff;
               rsp_area_in   = snap_area_ff;
               rsp_mean_in   = mean_res_ff;
               rsp_half_in   = half_res_ff;
               rsp_none_in   = (snap_area_ff == '0);
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         run_ff       <= '0;
         longest_ff   <= '0;
         area_ff      <= '0;
         wsum_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         run_ff       <= run_in;
         longest_ff   <= longest_in;
         area_ff      <= area_in;
         wsum_ff      <= wsum_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      cond_ff        <= cond_in;
      inf_ff         <= inf_in;
      cell_h_ff      <= cell_h_in;
      cell_a_ff      <= cell_a_in;
      col_last_ff    <= col_last_in;
      grid_last_ff   <= grid_last_in;
      prod_ff        <= prod_in;
      quo_ff         <= quo_in;
      rem_ff         <= rem_in;
      dvsr_ff        <= dvsr_in;
      snap_area_ff   <= snap_area_in;
      snap_height_ff <= snap_height_in;
      mean_res_ff    <= mean_res_in;
      half_res_ff    <= half_res_in;
      rsp_height_ff  <= rsp_height_in;
      rsp_area_ff    <= rsp_area_in;
      rsp_mean_ff    <= rsp_mean_in;
      rsp_half_ff    <= rsp_half_in;
      rsp_none_ff    <= rsp_none_in;
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.fracture_height   = rsp_height_ff;
   assign rsp_ch.open_area         = rsp_area_ff;
   assign rsp_ch.mean_conductivity = rsp_mean_ff;
   assign rsp_ch.half_length       = rsp_half_ff;
   assign rsp_ch.no_open_cells     = rsp_none_ff;

   // checks on the sequencer and result forming
   `FGM_ASSERT_NEXT(a_xfer_to_acc, req_xfer, state_ff == ST_ACC, "transfer not accumulated")
   `FGM_ASSERT_IMPLY(a_none_mean_zero, rsp_valid_ff && rsp_none_ff, rsp_mean_ff == '0, "mean set")
   `FGM_ASSERT_IMPLY(a_half_zero, rsp_valid_ff && ~|rsp_height_ff, rsp_half_ff == '0, "half set")
   `FGM_ASSERT_IMPLY(a_half_count, state_ff == ST_DIV_HALF, cnt_ff < CW'(HS), "divider overrun")

endmodule

// ----- tb/sv/fracture_grid_metrics_test.sv -----
// self-checking bench for fracture_grid_metrics: directed grids, saturating grids, random grids
// predicts each grid's metrics independently and compares every result transfer against it
// depends on fgm_pkg, fgm_intf and the fracture_grid_metrics rtl
module fracture_grid_metrics_test;

   localparam int COND_W     = fgm_pkg::COND_W;
   localparam int CELL_H_W   = fgm_pkg::CELL_H_W;
   localparam int CELL_A_W   = fgm_pkg::CELL_A_W;
   localparam int HEIGHT_W   = fgm_pkg::HEIGHT_W;
   localparam int AREA_W     = fgm_pkg::AREA_W;
   localparam int WSUM_W     = fgm_pkg::WSUM_W;
   localparam int MEAN_W     = fgm_pkg::MEAN_W;
   localparam int HALF_W     = fgm_pkg::HALF_W;
   localparam int PROD_W     = fgm_pkg::PROD_W;
   localparam int HALF_SHIFT = fgm_pkg::HALF_SHIFT;

   // one result transfer as it appears on the result channel
   typedef struct packed {
      logic [HEIGHT_W-1:0] fracture_height;
      logic [AREA_W-1:0]   open_area;
      logic [MEAN_W-1:0]   mean_conductivity;
      logic [HALF_W-1:0]   half_length;
      logic                no_open_cells;
   } metrics_type;

   localparam logic [COND_W-1:0]   COND_MAX        = {1'b0, {(COND_W-1){1'b1}}};
   localparam logic [COND_W-1:0]   COND_MIN        = {1'b1, {(COND_W-1){1'b0}}};
   localparam logic [CELL_H_W-1:0] CELL_HEIGHT_MAX = '1;
   localparam logic [CELL_A_W-1:0] CELL_AREA_MAX   = '1;

   localparam int CLOCK_PERIOD   = 10;
   localparam int RESET_CYCLES   = 8;
   // watchdog limit for the whole run, in clock periods
   localparam int TIMEOUT_CYCLES = 500_000;
   // watch time after the last pending grid arrives, for any stray result
   localparam int DRAIN_CYCLES   = 250;
   localparam int RANDOM_ITEMS   = 130;
   localparam int MAX_REPORTS    = 10;
   localparam int BURST_MAX      = 12;
   localparam int PATTERN_LEN    = 12;

   logic clock;
   logic reset;

   fgm_req_if req_ch ();
   fgm_rsp_if rsp_ch ();

   fracture_grid_metrics dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // predicted accumulator state, zero at start and cleared after every grid
   logic [HEIGHT_W-1:0] run_len      = '0;
   logic [HEIGHT_W-1:0] longest_len  = '0;
   logic [AREA_W-1:0]   area_acc     = '0;
   logic [WSUM_W-1:0]   weighted_acc = '0;

   // metrics still owed by the block, oldest first
   metrics_type pending_metrics[$];

   int error_count    = 0;
   // sender burst shaping
   int burst_left     = 0;
   int gap_max        = 3;
   // receiver stall shaping
   bit stall_receiver = 1'b1;
   logic [PATTERN_LEN-1:0] ready_pattern = '1;
   int ready_phase    = 0;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // fold one accepted cell into the predicted state; returns 1 with the grid's
   // metrics when the cell closes the grid
   function automatic bit predict_grid_metrics(
      input  logic [COND_W-1:0]   conductivity,
      input  logic                infinite,
      input  logic [CELL_H_W-1:0] height,
      input  logic [CELL_A_W-1:0] area,
      input  logic                column_last,
      input  logic                grid_last,
      output metrics_type         grid_metrics
   );
      logic              finite_open;
      logic              open_cell;
      logic [HEIGHT_W:0] run_sum;
      logic [AREA_W:0]   area_sum;
      logic [WSUM_W:0]   weighted_sum;
      logic [PROD_W-1:0] product;
      logic [63:0]       mean_q;
      logic [63:0]       area_wide;
      logic [63:0]       half_q;

      // infinite cells ignore the conductivity field entirely
      finite_open = !infinite && !conductivity[COND_W-1] && (conductivity != '0);
      open_cell   = infinite || finite_open;
      grid_metrics = '0;

      if (open_cell) begin
         run_sum = {1'b0, run_len} + (HEIGHT_W+1)'(height);
         run_len = run_sum[HEIGHT_W] ? '1 : run_sum[HEIGHT_W-1:0];
      end

      if (finite_open) begin
         product      = PROD_W'(conductivity) * PROD_W'(area);
         area_sum     = {1'b0, area_acc} + (AREA_W+1)'(area);
         area_acc     = area_sum[AREA_W] ? '1 : area_sum[AREA_W-1:0];
         weighted_sum = {1'b0, weighted_acc} + (WSUM_W+1)'(product);
         weighted_acc = weighted_sum[WSUM_W] ? '1 : weighted_sum[WSUM_W-1:0];
      end

      // a closed cell ends the run, as do the end of a column and the end of the grid
      if (!open_cell || column_last || grid_last) begin
         if (run_len > longest_len)
            longest_len = run_len;
         run_len = '0;
      end

      if (!grid_last)
         return 1'b0;

      grid_metrics.fracture_height = longest_len;
      grid_metrics.open_area       = area_acc;
      grid_metrics.no_open_cells   = (area_acc == '0);
      if (area_acc != '0) begin
         mean_q = weighted_acc / 64'(area_acc);
         grid_metrics.mean_conductivity = (mean_q > {MEAN_W{1'b1}}) ? '1 : mean_q[MEAN_W-1:0];
      end
      if (longest_len != '0) begin
         area_wide = 64'(area_acc);
         half_q    = (area_wide << HALF_SHIFT) / 64'(longest_len);
         grid_metrics.half_length = (half_q > {HALF_W{1'b1}}) ? '1 : half_q[HALF_W-1:0];
      end

      run_len      = '0;
      longest_len  = '0;
      area_acc     = '0;
      weighted_acc = '0;
      return 1'b1;
   endfunction

   // present one cell and hold it until the transfer; bursts end in a random gap
   task automatic send_cell(
      input logic [COND_W-1:0]   conductivity,
      input logic                infinite,
      input logic [CELL_H_W-1:0] height,
      input logic [CELL_A_W-1:0] area,
      input logic                column_last,
      input logic                grid_last
   );
      int          gap;
      metrics_type grid_metrics;

      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         // a zero gap keeps valid high, so it is never dropped and raised in one step
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, BURST_MAX);
      end

      req_ch.valid                 <= 1'b1;
      req_ch.conductivity          <= conductivity;
      req_ch.conductivity_infinite <= infinite;
      req_ch.cell_height           <= height;
      req_ch.cell_area             <= area;
      req_ch.column_last           <= column_last;
      req_ch.grid_last             <= grid_last;

      @(posedge clock);
      while (req_ch.ready !== 1'b1)
         @(posedge clock);
      burst_left--;

      if (predict_grid_metrics(conductivity, infinite, height, area, column_last, grid_last,
                               grid_metrics))
         pending_metrics = {pending_metrics, grid_metrics};
   endtask

   // with stalls on, receiver ready follows a random PATTERN_LEN-bit pattern, redrawn each period, never all low
   always @(posedge clock) begin
      if (ready_phase == 0)
         ready_pattern = PATTERN_LEN'($urandom_range(1, (1 << PATTERN_LEN) - 1));
      rsp_ch.ready <= !stall_receiver || ready_pattern[ready_phase];
      ready_phase = (ready_phase + 1) % PATTERN_LEN;
   end

   // result checker: every transfer is matched with the oldest pending grid
   always @(posedge clock) begin
      metrics_type seen;
      metrics_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         seen = {rsp_ch.fracture_height, rsp_ch.open_area, rsp_ch.mean_conductivity,
                 rsp_ch.half_length, rsp_ch.no_open_cells};
         // a transfer with nothing pending compares against all-x and so always fails
         if (pending_metrics.size() == 0)
            want = 'x;
         else
            want = pending_metrics.pop_front();
         if (seen !== want) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("result mismatch at %0t (expected/actual):", $time);
               $display("  height %h/%h area %h/%h mean %h/%h",
                        want.fracture_height, seen.fracture_height,
                        want.open_area, seen.open_area,
                        want.mean_conductivity, seen.mean_conductivity);
               $display("  half %h/%h none %b/%b",
                        want.half_length, seen.half_length,
                        want.no_open_cells, seen.no_open_cells);
            end
         end
      end
   end

   // field extremes, grid and column boundaries, infinite and closed cells, zero weight
   task automatic test_directed_cells();
      gap_max        = 3;
      stall_receiver = 1'b1;
      // single-cell grid at the top of every field
      send_cell(COND_MAX, 1'b0, CELL_HEIGHT_MAX, CELL_AREA_MAX, 1'b1, 1'b1);
      // grid ends without column_last; the zero-height, zero-area open cell keeps the run open
      send_cell(32'd1, 1'b0, 16'd0, 24'd0, 1'b0, 1'b0);
      send_cell(32'd1, 1'b0, 16'd1, 24'd1, 1'b0, 1'b1);
      // closed cells only: zero, most negative and minus one give no height, no weight
      send_cell(32'd0, 1'b0, CELL_HEIGHT_MAX, CELL_AREA_MAX, 1'b0, 1'b0);
      send_cell(COND_MIN, 1'b0, CELL_HEIGHT_MAX, CELL_AREA_MAX, 1'b1, 1'b0);
      send_cell('1, 1'b0, 16'd256, 24'd512, 1'b0, 1'b1);
      // infinite cells count toward height, never toward area
      send_cell(COND_MIN, 1'b1, 16'd300, CELL_AREA_MAX, 1'b0, 1'b0);
      send_cell(32'd256, 1'b0, 16'd100, 24'd1000, 1'b1, 1'b0);
      send_cell(32'd0, 1'b1, CELL_HEIGHT_MAX, CELL_AREA_MAX, 1'b0, 1'b0);
      send_cell(COND_MAX, 1'b1, CELL_HEIGHT_MAX, 24'd0, 1'b0, 1'b0);
      // a negative cell breaks the run in mid-column
      send_cell(32'hFFFF_FF00, 1'b0, 16'd50, 24'd50, 1'b0, 1'b0);
      send_cell(32'd640, 1'b0, 16'd20, 24'd3000, 1'b0, 1'b0);
      send_cell(32'd0, 1'b1, 16'd5, 24'd7, 1'b1, 1'b0);
      send_cell(32'd1, 1'b0, 16'd0, CELL_AREA_MAX, 1'b1, 1'b1);
      // open cells that all have zero area: height but no weight
      send_cell(32'd1000, 1'b0, 16'd256, 24'd0, 1'b0, 1'b0);
      send_cell(COND_MAX, 1'b0, 16'd256, 24'd0, 1'b1, 1'b1);
      // open cells of zero height: area but half-length stays zero
      send_cell(32'd77, 1'b0, 16'd0, 24'd9, 1'b1, 1'b0);
      send_cell(32'd78, 1'b0, 16'd0, 24'd10, 1'b1, 1'b1);
   endtask

   // one tall column of tall cells drives the run past its 24-bit limit
   task automatic test_height_saturation();
      gap_max = 2;
      for (int i = 0; i < 260; i++)
         send_cell(COND_MAX, 1'b0, CELL_HEIGHT_MAX, 24'd1, 1'b0, i == 259);
   endtask

   // one-cell columns of unit height at top conductivity and area: the half-length
   // passes its 36-bit limit
   task automatic test_half_length_saturation();
      gap_max        = 1;
      stall_receiver = 1'b0;
      for (int i = 0; i < 40; i++)
         send_cell(COND_MAX, 1'b0, 16'd1, CELL_AREA_MAX, 1'b1, i == 39);
   endtask

   // random grids, mostly small, with random column lengths and cell contents
   task automatic test_random_grids();
      int                  sent;
      int                  cells;
      int                  col_left;
      logic [COND_W-1:0]   cond;
      logic [CELL_H_W-1:0] height;
      logic [CELL_A_W-1:0] area;
      logic                infinite;
      logic                col_end;
      logic                grid_end;

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         cells = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         // some grids run back to back, others with sender gaps and receiver stalls
         gap_max        = ($urandom_range(0, 3) == 0) ? 0 : 6;
         stall_receiver = ($urandom_range(0, 3) != 0);
         col_left       = $urandom_range(1, 6);
         for (int i = 0; i < cells; i++) begin
            case ($urandom_range(0, 9))
               0:       cond = $urandom | COND_MIN;
               1:       cond = '0;
               2:       cond = COND_MAX;
               3:       cond = $urandom_range(1, 255);
               4:       cond = $urandom;
               default: cond = $urandom & COND_MAX;
            endcase
            infinite = ($urandom_range(0, 7) == 0);
            case ($urandom_range(0, 7))
               0:       height = '0;
               1:       height = CELL_HEIGHT_MAX;
               default: height = CELL_H_W'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 7))
               0:       area = '0;
               1:       area = CELL_AREA_MAX;
               2:       area = CELL_A_W'($urandom_range(1, 255));
               default: area = CELL_A_W'($urandom);
            endcase
            grid_end = (i == cells - 1);
            col_left--;
            // the last cell of the grid may or may not carry column_last
            col_end = (col_left == 0) || (grid_end && ($urandom_range(0, 1) == 1));
            if (col_left == 0)
               col_left = $urandom_range(1, 6);
            send_cell(cond, infinite, height, area, col_end, grid_end);
            sent++;
         end
      end
   endtask

   initial begin
      reset                        = 1'b1;
      req_ch.valid                 = 1'b0;
      req_ch.conductivity          = '0;
      req_ch.conductivity_infinite = 1'b0;
      req_ch.cell_height           = '0;
      req_ch.cell_area             = '0;
      req_ch.column_last           = 1'b0;
      req_ch.grid_last             = 1'b0;
      rsp_ch.ready                 = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_directed_cells();
      test_height_saturation();
      test_half_length_saturation();
      test_random_grids();
      req_ch.valid <= 1'b0;

      // let every pending grid arrive, then watch a while for anything extra
      while (pending_metrics.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // watchdog for a hung handshake or a missing result
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
